[design/urb_pkg.sv]
// urb_pkg: shared types and constants for the uart ring buffer core
// depends on nothing; imported by the top level, urb_ctrl and urb_dp
`default_nettype none

package urb_pkg;

	localparam int URB_RX_DEPTH = 128;
	localparam int URB_TX_DEPTH = 128;

	localparam int URB_IN_DATA_W  = 16;
	localparam int URB_IN_USER_W  = 3;
	localparam int URB_OUT_DATA_W = 40;
	localparam int URB_RX_LEVEL_W = 7;
	localparam int URB_TX_LEVEL_W = 8;

	typedef enum logic [1:0] {
		KIND_RX_BYTE  = 2'd0,
		KIND_TX_EMPTY = 2'd1,
		KIND_READ     = 2'd2,
		KIND_WRITE    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_RX_EMPTY = 2'd1,
		ST_TX_FULL  = 2'd2,
		ST_DROPPED  = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} urb_cmd_t;

	typedef struct packed {
		logic out_busy;
	} urb_stat_t;

endpackage

`default_nettype wire

[design/uart_rx_tx_ring_buffers_core.sv]
// uart_rx_tx_ring_buffers_core: top level of the uart receive/transmit ring buffer block
// depends on urb_pkg, urb_ctrl, urb_dp (which holds two urb_ram)
//
// channel  dir  bits            contents (lowest bit first)
// s_*      in   tdata[15:0]     data[7:0], transmitter_idle[8], zero pad
//                tuser[2:0]      kind[1:0], line_error[2]
// m_*      out  tdata[39:0]     status, send_valid, send_byte, read_valid, read_byte,
//                                overflow_flag, tx_irq_enabled, rx_level, tx_level, pad
//
// a transaction has an accept step to latch it and read both rings, then an update step
// to update and register the result; set by the registered read port of the ring rams
// a result waiting in the output register does not block the next accept; the
// update cycle stalls only while that register is still full
// arst_n clears pointers, counts and overflow; transmit irq enable resets to one
`default_nettype none

module uart_rx_tx_ring_buffers_core
	import urb_pkg::*;
#(
	parameter int RX_DEPTH = URB_RX_DEPTH,
	parameter int TX_DEPTH = URB_TX_DEPTH
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [URB_IN_DATA_W-1:0]  s_tdata,   // data, transmitter_idle
	input  wire logic [URB_IN_USER_W-1:0]  s_tuser,   // kind, line_error
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic      [URB_OUT_DATA_W-1:0] m_tdata    // status .. tx_level
);

	urb_cmd_t  cmd;
	urb_stat_t stat;

	urb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	urb_dp #(
		.RX_DEPTH (RX_DEPTH),
		.TX_DEPTH (TX_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

[design/urb_ram.sv]
// urb_ram: generic single-write, single-read ram with registered read data
// depends on nothing
`default_nettype none

module urb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[design/urb_ctrl.sv]
// urb_ctrl: two-state sequencer, takes one transaction and runs it
// depends on urb_pkg
`default_nettype none

module urb_ctrl
	import urb_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	input  wire urb_stat_t stat,
	output urb_cmd_t       cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		s_tready  = 1'b0;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load  = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!stat.out_busy) begin
					cmd.exec  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

[design/urb_dp.sv]
// urb_dp: ring pointers, counts, flags, both ring rams and the result register
// depends on urb_pkg and urb_ram
`default_nettype none

module urb_dp
	import urb_pkg::*;
#(
	parameter int RX_DEPTH = URB_RX_DEPTH,
	parameter int TX_DEPTH = URB_TX_DEPTH
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire urb_cmd_t                  cmd,
	output urb_stat_t                      stat,
	input  wire logic [URB_IN_DATA_W-1:0]  s_tdata,
	input  wire logic [URB_IN_USER_W-1:0]  s_tuser,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic      [URB_OUT_DATA_W-1:0] m_tdata
);

	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int TX_AW = $clog2(TX_DEPTH);
	localparam int RX_CW = $clog2(RX_DEPTH);
	localparam int TX_CW = $clog2(TX_DEPTH + 1);

	localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
	localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
	localparam logic [RX_CW:0]   RX_WRAP = (RX_CW + 1)'(RX_DEPTH);
	localparam logic [TX_CW-1:0] TX_FULL = TX_CW'(TX_DEPTH);

	// latched item
	kind_t      kind_q;
	logic [7:0] data_q;
	logic       lerr_q;
	logic       tidle_q;

	// ring state
	logic [RX_AW-1:0] rx_wr_q, rx_rd_q;
	logic [RX_CW-1:0] rx_cnt_q;
	logic             rx_ovf_q;
	logic [TX_AW-1:0] tx_wr_q, tx_rd_q;
	logic [TX_CW-1:0] tx_cnt_q;
	logic             tx_irq_q;

	logic [RX_AW-1:0] rx_wr_nxt, rx_rd_nxt;
	logic [RX_CW-1:0] rx_cnt_nxt;
	logic             rx_ovf_nxt;
	logic [TX_AW-1:0] tx_wr_nxt, tx_rd_nxt;
	logic [TX_CW-1:0] tx_cnt_nxt;
	logic             tx_irq_nxt;
	logic [RX_CW:0]   rx_cnt_inc;

	logic       rx_we, tx_we;
	logic [7:0] rx_rdata, tx_rdata;

	status_t    status_nxt;
	logic       send_v_nxt, read_v_nxt;
	logic [7:0] send_b_nxt, read_b_nxt;

	// result register
	logic       out_v_q;
	status_t    status_q;
	logic       send_v_q, read_v_q;
	logic [7:0] send_b_q, read_b_q;
	logic       ovf_o_q, irq_o_q;
	logic [URB_RX_LEVEL_W-1:0] rx_lvl_q;
	logic [URB_TX_LEVEL_W-1:0] tx_lvl_q;

	urb_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_wr_q),
		.wdata (data_q),
		.re    (cmd.load),
		.raddr (rx_rd_q),
		.rdata (rx_rdata)
	);

	urb_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_wr_q),
		.wdata (data_q),
		.re    (cmd.load),
		.raddr (tx_rd_q),
		.rdata (tx_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind_t'(s_tuser[1:0]);
			lerr_q  <= s_tuser[2];
			data_q  <= s_tdata[7:0];
			tidle_q <= s_tdata[8];
		end
	end

	always_comb begin
		rx_wr_nxt  = rx_wr_q;
		rx_rd_nxt  = rx_rd_q;
		rx_cnt_nxt = rx_cnt_q;
		rx_ovf_nxt = rx_ovf_q;
		tx_wr_nxt  = tx_wr_q;
		tx_rd_nxt  = tx_rd_q;
		tx_cnt_nxt = tx_cnt_q;
		tx_irq_nxt = tx_irq_q;
		rx_we      = 1'b0;
		tx_we      = 1'b0;
		status_nxt = ST_OK;
		send_v_nxt = 1'b0;
		send_b_nxt = 8'd0;
		read_v_nxt = 1'b0;
		read_b_nxt = 8'd0;
		rx_cnt_inc = {1'b0, rx_cnt_q} + 1'b1;
		case (kind_q)
			KIND_RX_BYTE: begin
				if (lerr_q) begin
					status_nxt = ST_DROPPED;
				end else begin
					rx_we     = cmd.exec;
					rx_wr_nxt = (rx_wr_q == RX_LAST) ? '0 : rx_wr_q + 1'b1;
					if (rx_cnt_inc >= RX_WRAP) begin
						rx_cnt_nxt = '0;
						rx_ovf_nxt = 1'b1;
					end else begin
						rx_cnt_nxt = rx_cnt_inc[RX_CW-1:0];
					end
				end
			end
			KIND_TX_EMPTY: begin
				if (tx_cnt_q != '0) begin
					tx_cnt_nxt = tx_cnt_q - 1'b1;
					send_v_nxt = 1'b1;
					send_b_nxt = tx_rdata;
					tx_rd_nxt  = (tx_rd_q == TX_LAST) ? '0 : tx_rd_q + 1'b1;
				end else begin
					tx_irq_nxt = 1'b0;
				end
			end
			KIND_READ: begin
				if (rx_cnt_q == '0) begin
					status_nxt = ST_RX_EMPTY;
				end else begin
					read_v_nxt = 1'b1;
					read_b_nxt = rx_rdata;
					rx_rd_nxt  = (rx_rd_q == RX_LAST) ? '0 : rx_rd_q + 1'b1;
					rx_cnt_nxt = rx_cnt_q - 1'b1;
				end
			end
			default: begin
				if (tx_cnt_q >= TX_FULL) begin
					status_nxt = ST_TX_FULL;
				end else if (tx_cnt_q != '0 || !tidle_q) begin
					tx_we      = cmd.exec;
					tx_wr_nxt  = (tx_wr_q == TX_LAST) ? '0 : tx_wr_q + 1'b1;
					tx_cnt_nxt = tx_cnt_q + 1'b1;
					tx_irq_nxt = 1'b1;
				end else begin
					tx_irq_nxt = 1'b0;
					send_v_nxt = 1'b1;
					send_b_nxt = data_q;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_wr_q  <= '0;
			rx_rd_q  <= '0;
			rx_cnt_q <= '0;
			rx_ovf_q <= 1'b0;
			tx_wr_q  <= '0;
			tx_rd_q  <= '0;
			tx_cnt_q <= '0;
			tx_irq_q <= 1'b1;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.exec) begin
				rx_wr_q  <= rx_wr_nxt;
				rx_rd_q  <= rx_rd_nxt;
				rx_cnt_q <= rx_cnt_nxt;
				rx_ovf_q <= rx_ovf_nxt;
				tx_wr_q  <= tx_wr_nxt;
				tx_rd_q  <= tx_rd_nxt;
				tx_cnt_q <= tx_cnt_nxt;
				tx_irq_q <= tx_irq_nxt;
				out_v_q  <= 1'b1;
			end else if (m_tready) begin
				out_v_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= status_nxt;
			send_v_q <= send_v_nxt;
			send_b_q <= send_b_nxt;
			read_v_q <= read_v_nxt;
			read_b_q <= read_b_nxt;
			ovf_o_q  <= rx_ovf_nxt;
			irq_o_q  <= tx_irq_nxt;
			rx_lvl_q <= URB_RX_LEVEL_W'(rx_cnt_nxt);
			tx_lvl_q <= URB_TX_LEVEL_W'(tx_cnt_nxt);
		end
	end

	assign stat.out_busy = out_v_q && !m_tready;
	assign m_tvalid      = out_v_q;
	assign m_tdata       = {3'd0, tx_lvl_q, rx_lvl_q, irq_o_q, ovf_o_q,
		read_b_q, read_v_q, send_b_q, send_v_q, status_q};

	a_rx_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, rx_cnt_q} < RX_WRAP)
		else $error("receive count reached ring depth");

	a_tx_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		tx_cnt_q <= TX_FULL)
		else $error("transmit count above ring depth");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !(out_v_q && !m_tready))
		else $error("result register overwritten before taken");

	a_one_byte_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(send_v_q && read_v_q))
		else $error("send and read both flagged in one result");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(rx_ovf_q) |-> rx_ovf_q)
		else $error("overflow flag dropped");

endmodule

`default_nettype wire
